/* design/lgbs_pkg.sv */
// ----------------------------------------------------------------------------
// lgbs_pkg
// shared types, register indexes and reset values for the led gesture
// button sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgbs_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_TOGGLES_NEEDED     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_TICKS        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_GAP_TICKS    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_DELAY_TICKS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BOOT_WAIT_TICKS    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RECHECK_TICKS      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS       = 3'd7;

  // register reset values
  localparam logic [3:0] RST_TOGGLES_NEEDED     = 4'd10;
  localparam logic [5:0] RST_WINDOW_TICKS       = 6'd10;
  localparam logic [3:0] RST_PRESS_TICKS        = 4'd2;
  localparam logic [5:0] RST_PULSE_GAP_TICKS    = 6'd10;
  localparam logic [7:0] RST_SIGNAL_DELAY_TICKS = 8'd50;
  localparam logic [5:0] RST_BOOT_WAIT_TICKS    = 6'd10;
  localparam logic [5:0] RST_RECHECK_TICKS      = 6'd20;
  localparam logic [5:0] RST_SETTLE_TICKS       = 6'd5;

  // signalling press counts
  localparam logic [2:0] PRESSES_MODE_ON  = 3'd4;
  localparam logic [2:0] PRESSES_MODE_OFF = 3'd2;

  typedef struct packed {
    logic [3:0] toggles_needed;
    logic [5:0] window_ticks;
    logic [3:0] press_ticks;
    logic [5:0] pulse_gap_ticks;
    logic [7:0] signal_delay_ticks;
    logic [5:0] boot_wait_ticks;
    logic [5:0] recheck_ticks;
    logic [5:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic button_drive;
    logic mode_flag;
    logic persist_write;
  } res_t;

  // a zero span length behaves as one tick
  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    at_least_one = (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

`default_nettype wire

/* design/lgbs_cfg.sv */
// ----------------------------------------------------------------------------
// lgbs_cfg
// configuration register file, one write per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgbs_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [lgbs_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  wire logic [lgbs_pkg::CFG_DATA_W-1:0]     wr_data,
  output lgbs_pkg::cfg_t                           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.toggles_needed     <= lgbs_pkg::RST_TOGGLES_NEEDED;
      cfg.window_ticks       <= lgbs_pkg::RST_WINDOW_TICKS;
      cfg.press_ticks        <= lgbs_pkg::RST_PRESS_TICKS;
      cfg.pulse_gap_ticks    <= lgbs_pkg::RST_PULSE_GAP_TICKS;
      cfg.signal_delay_ticks <= lgbs_pkg::RST_SIGNAL_DELAY_TICKS;
      cfg.boot_wait_ticks    <= lgbs_pkg::RST_BOOT_WAIT_TICKS;
      cfg.recheck_ticks      <= lgbs_pkg::RST_RECHECK_TICKS;
      cfg.settle_ticks       <= lgbs_pkg::RST_SETTLE_TICKS;
    end else if (wr_en) begin
      case (wr_index)
        lgbs_pkg::REG_TOGGLES_NEEDED:     cfg.toggles_needed     <= wr_data[3:0];
        lgbs_pkg::REG_WINDOW_TICKS:       cfg.window_ticks       <= wr_data[5:0];
        lgbs_pkg::REG_PRESS_TICKS:        cfg.press_ticks        <= wr_data[3:0];
        lgbs_pkg::REG_PULSE_GAP_TICKS:    cfg.pulse_gap_ticks    <= wr_data[5:0];
        lgbs_pkg::REG_SIGNAL_DELAY_TICKS: cfg.signal_delay_ticks <= wr_data;
        lgbs_pkg::REG_BOOT_WAIT_TICKS:    cfg.boot_wait_ticks    <= wr_data[5:0];
        lgbs_pkg::REG_RECHECK_TICKS:      cfg.recheck_ticks      <= wr_data[5:0];
        lgbs_pkg::REG_SETTLE_TICKS:       cfg.settle_ticks       <= wr_data[5:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/lgbs_core.sv */
// ----------------------------------------------------------------------------
// lgbs_core
// boot, gesture watch and signalling state machine, one tick per advance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgbs_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic           led,
  input  wire logic           saved,
  input  wire lgbs_pkg::cfg_t cfg,
  output lgbs_pkg::res_t      res
);

  typedef enum logic [2:0] {
    BOOT_WAIT   = 3'd0,
    RECHECK     = 3'd1,
    BOOT_PRESS  = 3'd2,
    BOOT_SETTLE = 3'd3,
    WATCH       = 3'd4,
    SIG_DELAY   = 3'd5,
    SIG_PRESS   = 3'd6,
    SIG_GAP     = 3'd7
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] tick_timer, tick_timer_next;
  logic [3:0] change_count, change_count_next;
  logic       last_led, last_led_next;
  logic       mode_bit, mode_bit_next;
  logic [2:0] presses_left, presses_left_next;

  logic [7:0] tick_inc;
  logic [7:0] span_limit;
  logic       span_done;
  logic [5:0] boot_limit;
  logic [3:0] count_inc;
  logic [2:0] presses_dec;
  logic       drive, strobe;

  assign tick_inc    = tick_timer + 8'd1;
  assign count_inc   = change_count + 4'd1;
  assign presses_dec = presses_left - 3'd1;
  assign boot_limit  = (phase == RECHECK) ? cfg.recheck_ticks : cfg.settle_ticks;

  // span length for the phase that counts a held or idle span
  always_comb begin
    case (phase)
      BOOT_PRESS, SIG_PRESS: span_limit = {4'd0, cfg.press_ticks};
      WATCH:                 span_limit = {2'd0, cfg.window_ticks};
      SIG_DELAY:             span_limit = cfg.signal_delay_ticks;
      SIG_GAP:               span_limit = {2'd0, cfg.pulse_gap_ticks};
      default:               span_limit = 8'd1;
    endcase
  end

  assign span_done = (tick_inc >= lgbs_pkg::at_least_one(span_limit));

  always_comb begin
    phase_next        = phase;
    tick_timer_next   = tick_timer;
    change_count_next = change_count;
    last_led_next     = last_led;
    mode_bit_next     = mode_bit;
    presses_left_next = presses_left;
    drive             = 1'b0;
    strobe            = 1'b0;

    case (phase)
      BOOT_WAIT: begin
        if (tick_timer >= {2'd0, cfg.boot_wait_ticks}) begin
          mode_bit_next   = saved;
          tick_timer_next = 8'd0;
          if (saved && !led) begin
            phase_next = RECHECK;
          end else begin
            phase_next        = WATCH;
            change_count_next = 4'd0;
            last_led_next     = led;
          end
        end else begin
          tick_timer_next = tick_inc;
        end
      end
      RECHECK, BOOT_SETTLE: begin
        if (tick_timer >= {2'd0, boot_limit}) begin
          tick_timer_next = 8'd0;
          if (led) begin
            phase_next        = WATCH;
            change_count_next = 4'd0;
            last_led_next     = led;
          end else if (phase == RECHECK) begin
            phase_next = BOOT_PRESS;
          end else begin
            phase_next = RECHECK;
          end
        end else begin
          tick_timer_next = tick_inc;
        end
      end
      BOOT_PRESS: begin
        drive           = 1'b1;
        tick_timer_next = span_done ? 8'd0 : tick_inc;
        if (span_done) begin
          phase_next = BOOT_SETTLE;
        end
      end
      WATCH: begin
        if (led != last_led) begin
          last_led_next   = led;
          tick_timer_next = 8'd0;
          if ({4'd0, count_inc} >= lgbs_pkg::at_least_one({4'd0, cfg.toggles_needed})) begin
            change_count_next = 4'd0;
            mode_bit_next     = !mode_bit;
            strobe            = 1'b1;
            presses_left_next = mode_bit ? lgbs_pkg::PRESSES_MODE_OFF
                                         : lgbs_pkg::PRESSES_MODE_ON;
            phase_next        = SIG_DELAY;
          end else begin
            change_count_next = count_inc;
          end
        end else if (span_done) begin
          tick_timer_next   = 8'd0;
          change_count_next = 4'd0;
        end else begin
          tick_timer_next = tick_inc;
        end
      end
      SIG_DELAY: begin
        tick_timer_next = span_done ? 8'd0 : tick_inc;
        if (span_done) begin
          phase_next = SIG_PRESS;
        end
      end
      SIG_PRESS: begin
        drive           = 1'b1;
        tick_timer_next = span_done ? 8'd0 : tick_inc;
        if (span_done) begin
          presses_left_next = presses_dec;
          if (presses_dec == 3'd0) begin
            phase_next        = WATCH;
            change_count_next = 4'd0;
          end else begin
            phase_next = SIG_GAP;
          end
        end
      end
      SIG_GAP: begin
        tick_timer_next = span_done ? 8'd0 : tick_inc;
        if (span_done) begin
          phase_next = SIG_PRESS;
        end
      end
      default: begin
        phase_next = BOOT_WAIT;
      end
    endcase
  end

  assign res.button_drive  = drive;
  assign res.mode_flag     = mode_bit_next;
  assign res.persist_write = strobe;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= BOOT_WAIT;
      tick_timer   <= 8'd0;
      change_count <= 4'd0;
      last_led     <= 1'b0;
      mode_bit     <= 1'b0;
      presses_left <= 3'd0;
    end else if (advance) begin
      phase        <= phase_next;
      tick_timer   <= tick_timer_next;
      change_count <= change_count_next;
      last_led     <= last_led_next;
      mode_bit     <= mode_bit_next;
      presses_left <= presses_left_next;
    end
  end

endmodule

`default_nettype wire

/* design/led_toggle_gesture_button_sequencer_top.sv */
// ----------------------------------------------------------------------------
// led_toggle_gesture_button_sequencer_top
// led gesture mode sequencer: tick items in, button / mode / persist out
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid / in_stall    | led_on, saved_mode
//  out     | out_valid / out_stall  | button_drive, mode_flag, persist_write
//  cfg     | cfg_valid / cfg_ready  | cfg_index (3 bit), cfg_data (8 bit)
//
//  one tick beat per clock while in_stall is low; an accepted beat's result
//  shows at the output after it passes the input register, then the result register
//  the state machine steps once per beat as it moves into the result register
//  rst is synchronous: it clears the state, the stage valids and restores
//  register defaults; no clearing pass is needed
//  while a result waits under out_stall one more beat is taken into the
//  input register, after that in_stall rises
//  cfg_ready is always high; writes are expected only while idle
//
`timescale 1ns / 1ps
`default_nettype none

module led_toggle_gesture_button_sequencer_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // tick beats in
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic                             led_on,
  input  wire logic                             saved_mode,
  // result beats out
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic                             button_drive,
  output      logic                             mode_flag,
  output      logic                             persist_write,
  // register writes
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [lgbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lgbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lgbs_pkg::cfg_t cfg;
  lgbs_pkg::res_t res;

  // input register
  logic s1_valid;
  logic s1_led;
  logic s1_saved;

  logic in_take;
  logic advance;

  assign cfg_ready = 1'b1;

  // the held beat moves on when the result register is empty or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  lgbs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lgbs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .led     (s1_led),
    .saved   (s1_saved),
    .cfg     (cfg),
    .res     (res)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_led   <= led_on;
      s1_saved <= saved_mode;
    end
    if (advance) begin
      button_drive  <= res.button_drive;
      mode_flag     <= res.mode_flag;
      persist_write <= res.persist_write;
    end
  end

endmodule

`default_nettype wire

/* design/lgbs_checker.sv */
// ----------------------------------------------------------------------------
// lgbs_checker
// port-level checks on the sequencer top, attached by bind
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgbs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic button_drive,
  input wire logic mode_flag,
  input wire logic persist_write
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({button_drive, mode_flag, persist_write}))
    else $error("stalled result beat changed");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

  // the toggle tick is a watch tick, never a press tick
  a_strobe_no_press: assert property (@(posedge clk) disable iff (rst)
    out_valid && persist_write |-> !button_drive)
    else $error("persist strobe together with button drive");

  // input side only backs up behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind led_toggle_gesture_button_sequencer_top lgbs_checker u_lgbs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .button_drive  (button_drive),
  .mode_flag     (mode_flag),
  .persist_write (persist_write)
);

`default_nettype wire
